// ----- src/lig_pkg.sv -----
// Package: shared constants, types and helpers for the interpolation gradient core.
`timescale 1ns / 1ps
package lig_pkg;

  localparam int MAX_KNOTS  = 64;
  localparam int IDX_W      = $clog2(MAX_KNOTS);
  localparam int KCNT_W     = IDX_W + 1;
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         knot_index;
    logic signed [DATA_W-1:0] knot_x;
    logic signed [DATA_W-1:0] knot_y;
    logic signed [DATA_W-1:0] query_t;
    logic signed [DATA_W-1:0] query_weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               result_kind;
    logic signed [DATA_W-1:0] query_grad;
    logic signed [DATA_W-1:0] knot_grad;
  } out_item_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE, S_RD_ACC, S_Q_INIT, S_WALK, S_WALK_CHK, S_TOP_RD, S_TOP_CHK, S_BOT,
    S_SEG_RD0, S_SEG_RD1, S_SEG_CAP, S_MUL_LO, S_MUL_HI, S_DIV_INIT, S_DIV,
    S_DIV_END, S_ACC_RD, S_ACC_WR, S_FINISH
  } state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RD_ACC, OP_Q_INIT, OP_WALK_RD, OP_WALK_DEC, OP_TOP_RD,
    OP_TOP_CHK, OP_BOT, OP_SEG_RD0, OP_SEG_RD1, OP_SEG_CAP, OP_MUL_LO, OP_MUL_HI,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_ACC_RD, OP_ACC_WR, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_is_nk;
    logic t_gt;
    logic div_done;
    logic sel_s;
    logic pair_pending;
    logic out_free;
  } dp_status_t;

  // Saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W+1:0] hi;
    logic signed [DATA_W+1:0] lo;
    hi = {{2{1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
    lo = {{2{1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};
    if (v > hi) begin
      sat34 = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      sat34 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat34 = v[DATA_W-1:0];
    end
  endfunction

endpackage

// ----- src/lig_ctrl.sv -----
// Controller: sequences load, read and query transactions through the datapath.
`timescale 1ns / 1ps
module lig_ctrl import lig_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req_type)
            REQ_QUERY: state_nxt = S_Q_INIT;
            REQ_READ:  state_nxt = S_RD_ACC;
            default:   state_nxt = S_FINISH;
          endcase
        end
      end
      S_RD_ACC:   state_nxt = S_FINISH;
      S_Q_INIT:   state_nxt = S_WALK;
      S_WALK: begin
        if (st.k_zero) begin
          state_nxt = S_BOT;
        end else if (st.k_is_nk) begin
          state_nxt = S_TOP_RD;
        end else begin
          state_nxt = S_WALK_CHK;
        end
      end
      S_WALK_CHK: state_nxt = st.t_gt ? S_SEG_RD0 : S_WALK;
      S_TOP_RD:   state_nxt = S_TOP_CHK;
      S_TOP_CHK:  state_nxt = st.t_gt ? S_ACC_RD : S_WALK;
      S_BOT:      state_nxt = S_ACC_RD;
      S_SEG_RD0:  state_nxt = S_SEG_RD1;
      S_SEG_RD1:  state_nxt = S_SEG_CAP;
      S_SEG_CAP:  state_nxt = S_MUL_LO;
      S_MUL_LO:   state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_DIV_INIT;
      S_DIV_INIT: state_nxt = S_DIV;
      S_DIV:      state_nxt = st.div_done ? S_DIV_END : S_DIV;
      S_DIV_END:  state_nxt = st.sel_s ? S_ACC_RD : S_MUL_LO;
      S_ACC_RD:   state_nxt = S_ACC_WR;
      S_ACC_WR:   state_nxt = st.pair_pending ? S_ACC_RD : S_FINISH;
      S_FINISH:   state_nxt = st.out_free ? S_IDLE : S_FINISH;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid && in_req_type == REQ_LOAD) begin
          cmd.op = OP_LOAD;
        end
      end
      S_RD_ACC:   cmd.op = OP_RD_ACC;
      S_Q_INIT:   cmd.op = OP_Q_INIT;
      S_WALK: begin
        if (!st.k_zero && !st.k_is_nk) begin
          cmd.op = OP_WALK_RD;
        end
      end
      S_WALK_CHK: cmd.op = st.t_gt ? OP_NONE : OP_WALK_DEC;
      S_TOP_RD:   cmd.op = OP_TOP_RD;
      S_TOP_CHK:  cmd.op = OP_TOP_CHK;
      S_BOT:      cmd.op = OP_BOT;
      S_SEG_RD0:  cmd.op = OP_SEG_RD0;
      S_SEG_RD1:  cmd.op = OP_SEG_RD1;
      S_SEG_CAP:  cmd.op = OP_SEG_CAP;
      S_MUL_LO:   cmd.op = OP_MUL_LO;
      S_MUL_HI:   cmd.op = OP_MUL_HI;
      S_DIV_INIT: cmd.op = OP_DIV_INIT;
      S_DIV:      cmd.op = st.div_done ? OP_NONE : OP_DIV_STEP;
      S_DIV_END:  cmd.op = OP_DIV_END;
      S_ACC_RD:   cmd.op = OP_ACC_RD;
      S_ACC_WR:   cmd.op = OP_ACC_WR;
      S_FINISH:   cmd.op = st.out_free ? OP_FINISH : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- src/lig_dp.sv -----
// Datapath: knot stores, segment pointer, multiplier, shared divider, output register.
`timescale 1ns / 1ps
module lig_dp import lig_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_status_t        st,
  input  in_item_t          in_data,
  input  logic              cfg_wr_en,
  input  logic [KCNT_W-1:0] cfg_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int MUL_LO_W = 17;
  localparam int DIFF_W   = DATA_W + 1;
  localparam int NUM_W    = 2 * DATA_W;
  localparam int P_LO_W   = DATA_W + MUL_LO_W;
  localparam logic [5:0] DIV_STEPS = 6'(DATA_W);

  // Memories
  logic signed [DATA_W-1:0] x_mem   [MAX_KNOTS];
  logic signed [DATA_W-1:0] y_mem   [MAX_KNOTS];
  logic signed [DATA_W-1:0] acc_mem [MAX_KNOTS];

  logic [KCNT_W-1:0]        num_knots_r;
  logic [KCNT_W-1:0]        ptr_r, k_r;
  in_item_t                 item_r;
  logic signed [DATA_W-1:0] x_rd_r, y_rd_r, acc_rd_r, x0_r, y0_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, ds_r;
  logic [DATA_W-1:0]        mw_r;
  logic [DIFF_W-1:0]        md_r, mden_r;
  logic                     neg_r, num_zero_r, ovf_r, sel_s_r, pair_r;
  logic [P_LO_W-1:0]        p_lo_r;
  logic [NUM_W-MUL_LO_W-1:0] p_hi_r;
  logic [DIFF_W-1:0]        rem_r;
  logic [DATA_W-1:0]        quo_r;
  logic [5:0]               cnt_r;
  logic signed [DATA_W-1:0] qgrad_r, s_r;
  logic [IDX_W-1:0]         acc_idx_r;
  logic signed [DIFF_W-1:0] addend_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  // Effective knot count, clamped to [2, MAX_KNOTS]
  logic [KCNT_W-1:0] nk;
  always_comb begin
    if (num_knots_r < KCNT_W'(2)) begin
      nk = KCNT_W'(2);
    end else if (num_knots_r > KCNT_W'(MAX_KNOTS)) begin
      nk = KCNT_W'(MAX_KNOTS);
    end else begin
      nk = num_knots_r;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_knots_r <= KCNT_W'(MAX_KNOTS);
    end else if (cfg_wr_en) begin
      num_knots_r <= cfg_wr_data;
    end
  end

  // Memory addressing
  logic [KCNT_W-1:0] k_m1, nk_m1;
  logic [IDX_W-1:0]  xy_addr;
  logic              xy_re;
  assign k_m1  = k_r - KCNT_W'(1);
  assign nk_m1 = nk - KCNT_W'(1);

  always_comb begin
    xy_re   = 1'b0;
    xy_addr = k_m1[IDX_W-1:0];
    unique case (cmd.op)
      OP_TOP_RD:  begin xy_re = 1'b1; xy_addr = nk_m1[IDX_W-1:0]; end
      OP_WALK_RD: begin xy_re = 1'b1; xy_addr = k_m1[IDX_W-1:0]; end
      OP_SEG_RD0: begin xy_re = 1'b1; xy_addr = k_m1[IDX_W-1:0]; end
      OP_SEG_RD1: begin xy_re = 1'b1; xy_addr = k_r[IDX_W-1:0]; end
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      x_mem[in_data.knot_index] <= in_data.knot_x;
    end
    if (xy_re) begin
      x_rd_r <= x_mem[xy_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      y_mem[in_data.knot_index] <= in_data.knot_y;
    end
    if (xy_re) begin
      y_rd_r <= y_mem[xy_addr];
    end
  end

  // Accumulator memory
  logic                     acc_we, acc_re;
  logic [IDX_W-1:0]         acc_wa, acc_ra;
  logic signed [DATA_W-1:0] acc_wd;
  always_comb begin
    acc_we = 1'b0;
    acc_wa = acc_idx_r;
    acc_wd = sat34(34'(acc_rd_r) + 34'(addend_r));
    acc_re = 1'b0;
    acc_ra = acc_idx_r;
    if (cmd.op == OP_LOAD) begin
      acc_we = 1'b1;
      acc_wa = in_data.knot_index;
      acc_wd = '0;
    end else if (cmd.op == OP_ACC_WR) begin
      acc_we = 1'b1;
    end
    if (cmd.op == OP_RD_ACC) begin
      acc_re = 1'b1;
      acc_ra = item_r.knot_index;
    end else if (cmd.op == OP_ACC_RD) begin
      acc_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (acc_re) begin
      acc_rd_r <= acc_mem[acc_ra];
    end
  end

  // Segment pointer and walk index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= KCNT_W'(MAX_KNOTS);
    end else begin
      unique case (cmd.op)
        OP_LOAD:    ptr_r <= KCNT_W'(MAX_KNOTS);
        OP_TOP_CHK: if (st.t_gt) ptr_r <= nk;
        OP_BOT:     ptr_r <= '0;
        OP_SEG_RD0: ptr_r <= k_r;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_Q_INIT:   k_r <= (ptr_r > nk) ? nk : ptr_r;
      OP_TOP_CHK:  if (!st.t_gt) k_r <= nk_m1;
      OP_WALK_DEC: k_r <= k_m1;
      default:     ;
    endcase
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // Segment differences
  logic signed [DIFF_W-1:0] w_ext;
  assign w_ext = DIFF_W'(item_r.query_weight);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SEG_RD1) begin
      x0_r <= x_rd_r;
      y0_r <= y_rd_r;
    end
    if (cmd.op == OP_SEG_CAP) begin
      dx_r <= DIFF_W'(x_rd_r) - DIFF_W'(x0_r);
      dy_r <= DIFF_W'(y_rd_r) - DIFF_W'(y0_r);
      ds_r <= DIFF_W'(item_r.query_t) - DIFF_W'(x0_r);
    end
  end

  // Multiplier on magnitudes, two partial products: low in MUL_LO, high in MUL_HI
  logic signed [DIFF_W-1:0] d_sel;
  logic [DIFF_W-1:0]        d_mag, dx_mag;
  logic [DATA_W-1:0]        w_mag;
  assign d_sel  = sel_s_r ? ds_r : dy_r;
  assign d_mag  = d_sel[DIFF_W-1] ? DIFF_W'(-d_sel) : DIFF_W'(d_sel);
  assign dx_mag = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
  assign w_mag  = item_r.query_weight[DATA_W-1] ? DATA_W'(-w_ext) : item_r.query_weight;

  logic [NUM_W-1:0] num;
  assign num = NUM_W'(p_lo_r) + (NUM_W'(p_hi_r) << MUL_LO_W);

  // Shared restoring divider: 32 quotient bits, one per step
  logic [DIFF_W:0]  trial;
  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, mden_r};

  // Signed, saturated quotient
  logic signed [DATA_W-1:0] div_res;
  always_comb begin
    if (num_zero_r) begin
      div_res = '0;
    end else if (!neg_r) begin
      div_res = (ovf_r || quo_r[DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}} : quo_r;
    end else if (ovf_r || quo_r > {1'b1, {(DATA_W-1){1'b0}}}) begin
      div_res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      div_res = -quo_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_SEG_CAP: sel_s_r <= 1'b0;
      OP_MUL_LO: begin
        mw_r   <= w_mag;
        md_r   <= d_mag;
        mden_r <= dx_mag;
        neg_r  <= item_r.query_weight[DATA_W-1] ^ d_sel[DIFF_W-1] ^ dx_r[DIFF_W-1];
        p_lo_r <= P_LO_W'(w_mag * d_mag[MUL_LO_W-1:0]);
      end
      OP_MUL_HI: p_hi_r <= (NUM_W-MUL_LO_W)'(mw_r * md_r[DIFF_W-1:MUL_LO_W]);
      OP_DIV_INIT: begin
        num_zero_r <= (num == '0);
        ovf_r      <= ({1'b0, num[NUM_W-1:DATA_W]} >= mden_r);
        rem_r      <= {1'b0, num[NUM_W-1:DATA_W]};
        quo_r      <= num[DATA_W-1:0];
        cnt_r      <= DIV_STEPS;
      end
      OP_DIV_STEP: begin
        if (!trial[DIFF_W]) begin
          rem_r <= trial[DIFF_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DIFF_W-2:0], quo_r[DATA_W-1]};
          quo_r <= {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      OP_DIV_END: begin
        if (!sel_s_r) begin
          qgrad_r <= div_res;
          sel_s_r <= 1'b1;
        end else begin
          s_r <= div_res;
        end
      end
      default: ;
    endcase
  end

  // Accumulator update plan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_TOP_CHK: begin
          acc_idx_r <= nk_m1[IDX_W-1:0];
          addend_r  <= w_ext;
          pair_r    <= 1'b0;
        end
        OP_BOT: begin
          acc_idx_r <= '0;
          addend_r  <= w_ext;
          pair_r    <= 1'b0;
        end
        OP_DIV_END: begin
          if (sel_s_r) begin
            acc_idx_r <= k_m1[IDX_W-1:0];
            addend_r  <= w_ext - DIFF_W'(div_res);
            pair_r    <= 1'b1;
          end
        end
        OP_ACC_WR: begin
          if (pair_r) begin
            acc_idx_r <= k_r[IDX_W-1:0];
            addend_r  <= DIFF_W'(s_r);
            pair_r    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Query gradient, zero unless a query landed inside a segment
  logic signed [DATA_W-1:0] qgrad_out;
  assign qgrad_out = (item_r.req_type == REQ_QUERY && k_r != '0 && ptr_r == k_r
                      && k_r < nk) ? qgrad_r : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_r.result_kind <= item_r.req_type;
      out_r.query_grad  <= qgrad_out;
      out_r.knot_grad   <= (item_r.req_type == REQ_READ) ? acc_rd_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to controller
  assign st.k_zero       = (k_r == '0);
  assign st.k_is_nk      = (k_r == nk);
  assign st.t_gt         = (item_r.query_t > x_rd_r);
  assign st.div_done     = (cnt_r == '0);
  assign st.sel_s        = sel_s_r;
  assign st.pair_pending = pair_r;
  assign st.out_free     = !out_valid_r || !out_stall;

endmodule

// ----- src/linear_interp_gradient_core.sv -----
// Top level: backward pass of piecewise-linear interpolation over a knot table.
// One transaction at a time. A load or an unknown request goes straight to posting
// its result; a read first reads its accumulator. A query walks the segment pointer
// down one knot at a time, then inside a segment reads both knots and runs two
// multiply-divides on one shared restoring divider (one quotient bit per cycle), then
// updates two accumulators. Queries outside the table skip the divider and update one
// accumulator. The result register frees the input side once a result is posted.
`timescale 1ns / 1ps
module linear_interp_gradient_core import lig_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [KCNT_W-1:0] cfg_wr_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  lig_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .st          (st),
    .cmd         (cmd)
  );

  lig_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- src/lig_chk.sv -----
// Port-level checker for the interpolation gradient core, bound to the top level.
`timescale 1ns / 1ps
module lig_chk import lig_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_stall
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One transaction at a time: busy right after accepting
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // Only a query reports a query gradient
  a_qgrad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != REQ_QUERY |-> out_data.query_grad == '0)
    else $error("query gradient on non-query result");

  // Only a read reports a knot gradient
  a_kgrad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != REQ_READ |-> out_data.knot_grad == '0)
    else $error("knot gradient on non-read result");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind linear_interp_gradient_core lig_chk u_lig_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

// ----- test/linear_interp_gradient_checker.sv -----
// Checker: predicts the interpolation gradient results and compares them with the core's output.
`timescale 1ns / 1ps
module linear_interp_gradient_checker import lig_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [KCNT_W-1:0] cfg_wr_data,
  output int                fail_count,
  output int                results_seen,
  output int                pending
);

  localparam longint POS_LIMIT = 64'sd2147483647;
  localparam longint NEG_LIMIT = -64'sd2147483648;

  // Shadow copy of the core's tables, pointer and knot count
  longint           knot_abscissa [MAX_KNOTS];
  longint           knot_ordinate [MAX_KNOTS];
  longint           knot_grad_sum [MAX_KNOTS];
  int               seg_ptr;
  logic [KCNT_W-1:0] knot_count;
  out_item_t        expected_results [$];

  function automatic longint clamp32(input longint v);
    if (v > POS_LIMIT) begin
      return POS_LIMIT;
    end
    if (v < NEG_LIMIT) begin
      return NEG_LIMIT;
    end
    return v;
  endfunction

  // Exact quotient truncated toward zero; zero divisor saturates by numerator sign
  function automatic longint quot_sat(input longint num, input longint den);
    if (den == 0) begin
      if (num > 0) return POS_LIMIT;
      if (num < 0) return NEG_LIMIT;
      return 0;
    end
    return clamp32(num / den);
  endfunction

  function automatic void add_grad(input int i, input longint v);
    knot_grad_sum[i] = clamp32(knot_grad_sum[i] + v);
  endfunction

  // Work out the result of one accepted transaction and update the shadow state
  function automatic out_item_t gradient_result(input in_item_t it);
    out_item_t r;
    int        nk;
    int        k;
    int        n;
    bit        done;
    longint    t;
    longint    w;
    longint    dx;
    longint    dy;
    longint    s;
    r.result_kind = it.req_type;
    r.query_grad  = '0;
    r.knot_grad   = '0;
    case (req_kind_t'(it.req_type))
      REQ_LOAD: begin
        knot_abscissa[it.knot_index] = longint'(it.knot_x);
        knot_ordinate[it.knot_index] = longint'(it.knot_y);
        knot_grad_sum[it.knot_index] = 0;
        seg_ptr = MAX_KNOTS;
      end
      REQ_QUERY: begin
        nk = (knot_count < 2) ? 2 : (knot_count > MAX_KNOTS) ? MAX_KNOTS : int'(knot_count);
        t = longint'(it.query_t);
        w = longint'(it.query_weight);
        k = (seg_ptr > nk) ? nk : seg_ptr;
        done = 1'b0;
        if (k == nk) begin
          if (t > knot_abscissa[nk-1]) begin
            add_grad(nk - 1, w);
            done = 1'b1;
          end else begin
            k = nk - 1;
          end
        end
        if (!done) begin
          while (k >= 1 && !(t > knot_abscissa[k-1])) k--;
          if (k == 0) begin
            add_grad(0, w);
          end else begin
            n  = k - 1;
            dx = knot_abscissa[n+1] - knot_abscissa[n];
            dy = knot_ordinate[n+1] - knot_ordinate[n];
            s  = quot_sat(w * (t - knot_abscissa[n]), dx);
            r.query_grad = DATA_W'(quot_sat(w * dy, dx));
            add_grad(n, w - s);
            add_grad(n + 1, s);
          end
          seg_ptr = k;
        end else begin
          seg_ptr = nk;
        end
      end
      REQ_READ: begin
        r.knot_grad = DATA_W'(knot_grad_sum[it.knot_index]);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  // Compare each result with the oldest expectation, then predict new transactions
  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (!rst_n) begin
      for (int i = 0; i < MAX_KNOTS; i++) begin
        knot_abscissa[i] = 0;
        knot_ordinate[i] = 0;
        knot_grad_sum[i] = 0;
      end
      seg_ptr = MAX_KNOTS;
      knot_count = KCNT_W'(MAX_KNOTS);
      expected_results.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          bad = 1'b0;
          if (out_data.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d got %0d", want.result_kind, out_data.result_kind);
            bad = 1'b1;
          end
          if (out_data.query_grad !== want.query_grad) begin
            $error("query_grad expected %0d got %0d", want.query_grad, out_data.query_grad);
            bad = 1'b1;
          end
          if (out_data.knot_grad !== want.knot_grad) begin
            $error("knot_grad expected %0d got %0d", want.knot_grad, out_data.knot_grad);
            bad = 1'b1;
          end
          if (bad) begin
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(gradient_result(in_data));
      end
      if (cfg_wr_en) begin
        knot_count = cfg_wr_data;
      end
    end
  end

endmodule

// ----- test/linear_interp_gradient_core_tb.sv -----
// Testbench top: stimulus, handshake idling and verdict for the interpolation gradient core.
`timescale 1ns / 1ps
module linear_interp_gradient_core_tb import lig_pkg::*;;

  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_wr_en;
  logic [KCNT_W-1:0] cfg_wr_data;
  int                fail_count;
  int                results_seen;
  int                pending;
  int                sent;
  int                random_items;
  bit                idle_on;
  bit                hold_request;
  longint            top_x;
  longint            low_x;

  linear_interp_gradient_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  linear_interp_gradient_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .results_seen(results_seen),
    .pending     (pending)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Safety limit on run time
  initial begin
    #20_000_000;
    $display("FAIL linear_interp_gradient_core");
    $finish;
  end

  // Receiver: short random stall bursts, plus a long hold whenever one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Send one transaction and wait for it to be taken
  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Transaction with every field randomized, kind and index set by the caller
  function automatic in_item_t noisy_item(input req_kind_t kind, input int idx);
    in_item_t it;
    it.req_type     = kind;
    it.knot_index   = idx[IDX_W-1:0];
    it.knot_x       = $urandom;
    it.knot_y       = $urandom;
    it.query_t      = $urandom;
    it.query_weight = $urandom;
    return it;
  endfunction

  task automatic load_knot(input int idx, input longint x, input longint y);
    in_item_t it;
    it = noisy_item(REQ_LOAD, idx);
    it.knot_x = x[31:0];
    it.knot_y = y[31:0];
    send_item(it);
  endtask

  task automatic query(input longint t, input longint w);
    in_item_t it;
    it = noisy_item(REQ_QUERY, $urandom_range(0, 63));
    it.query_t      = t[31:0];
    it.query_weight = w[31:0];
    send_item(it);
  endtask

  // Drain the core, then write the knot count
  task automatic set_knot_count(input int n);
    in_valid <= 1'b0;
    wait (results_seen == sent);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n[KCNT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Load an ascending table into knots 0..n-1, some spacings zero
  task automatic load_table(input int n);
    longint x;
    x = longint'($urandom_range(0, 32'h6000_0000)) - 64'sh4000_0000;
    low_x = x;
    for (int i = 0; i < n; i++) begin
      load_knot(i, x, longint'(signed'($urandom)));
      top_x = x;
      if ($urandom_range(0, 7) != 0) x += $urandom_range(1, 1 << 22);
    end
  endtask

  function automatic longint rand_weight();
    case ($urandom_range(0, 3))
      0: return longint'(signed'($urandom));
      1: return ($urandom_range(0, 1) != 0) ? 64'sd2147483647 : -64'sd2147483648;
      default: return longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  // One pass of mostly ordered queries with reads, loads and noise mixed in
  task automatic query_pass(input int count);
    longint t;
    longint step;
    int     pick;
    t = top_x + $urandom_range(1, 1000);
    step = (top_x - low_x) / 16 + 2;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        query(t, rand_weight());
        t -= $urandom_range(0, step);
        if (t < -64'sd2147483648) t = -64'sd2147483648;
      end else if (pick < 84) begin
        send_item(noisy_item(REQ_READ, $urandom_range(0, 63)));
      end else if (pick < 89) begin
        send_item(noisy_item(REQ_NONE, $urandom_range(0, 63)));
      end else if (pick < 95) begin
        query(t + $urandom_range(1, step), rand_weight());
      end else begin
        load_knot($urandom_range(0, 63), longint'(signed'($urandom)),
                  longint'(signed'($urandom)));
        t = 64'sd2147483647;
      end
    end
  endtask

  initial begin
    int counts[];
    int n_cfg;
    int n_eff;
    counts       = '{2, 3, 64, 0, 1, 127, 5, 17};
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    sent         = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot so no read ever touches an unwritten entry
    load_table(MAX_KNOTS);

    // Directed: two knots at the extremes of the range
    set_knot_count(2);
    load_knot(0, -64'sd2147483648, 64'sd2147483647);
    load_knot(1, 64'sd2147483647, -64'sd2147483648);
    query(64'sd2147483647, 64'sd2147483647);
    query(0, 64'sd2147483647);
    query(0, -64'sd2147483648);
    query(-64'sd2147483647, -64'sd2147483648);
    query(-64'sd2147483648, 64'sd2147483647);
    query(100, 5 << 16);
    send_item(noisy_item(REQ_READ, 0));
    send_item(noisy_item(REQ_READ, 1));
    send_item(noisy_item(REQ_NONE, 63));
    // Above the top knot, then an out-of-order query inside the segment
    load_knot(1, 10 << 16, 3 << 16);
    query(20 << 16, 1 << 16);
    query(5 << 16, 1 << 16);
    query(8 << 16, 1 << 16);
    query(-5, 1 << 16);
    send_item(noisy_item(REQ_READ, 0));
    send_item(noisy_item(REQ_READ, 1));
    send_item(noisy_item(REQ_READ, 63));

    // Random phases over several knot counts
    random_items = 0;
    while (random_items < 440) begin
      n_cfg = (random_items < 320) ? counts[$urandom_range(0, counts.size() - 1)]
                                   : $urandom_range(2, 12);
      n_eff = (n_cfg < 2) ? 2 : (n_cfg > MAX_KNOTS) ? MAX_KNOTS : n_cfg;
      idle_on = (random_items < 360);
      set_knot_count(n_cfg);
      if (n_eff > 20 && $urandom_range(0, 2) != 0) begin
        // big tables only reloaded sometimes; keep the rest from the previous fill
        load_knot(0, low_x, longint'(signed'($urandom)));
      end else begin
        load_table(n_eff);
      end
      if (random_items > 100 && random_items < 200) begin
        hold_request = 1'b1;
      end
      query_pass(40);
      random_items += 40;
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    wait (results_seen == sent);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS linear_interp_gradient_core");
    end else begin
      $display("FAIL linear_interp_gradient_core");
    end
    $finish;
  end

endmodule
